// ----- rtl/ptd_pkg.sv -----
// Shared types for the trial-division primality tester.
package ptd_pkg;

    // Status that the remainder unit reports back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_rem_status;

endpackage

// ----- rtl/ptd_rem_unit.sv -----
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module ptd_rem_unit #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NUMBER_WIDTH-1:0]  i_dividend,
    input  logic [NUMBER_WIDTH-1:0]  i_divisor,
    output ptd_pkg::t_rem_status     o_status
);
    import ptd_pkg::*;

    localparam int CntWidth = $clog2(NUMBER_WIDTH + 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CntWidth-1:0]     r_cnt;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] r_shift;
    logic [NUMBER_WIDTH-1:0] r_divisor;

    logic [NUMBER_WIDTH:0]   shifted;
    logic [NUMBER_WIDTH:0]   diff;
    logic [NUMBER_WIDTH-1:0] n_rem;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        shifted = {r_rem, r_shift[NUMBER_WIDTH-1]};
        diff    = shifted - {1'b0, r_divisor};
        if (!diff[NUMBER_WIDTH]) begin
            n_rem = diff[NUMBER_WIDTH-1:0];
        end else begin
            n_rem = shifted[NUMBER_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntWidth'(NUMBER_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntWidth'(1);
                if (r_cnt == CntWidth'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_shift   <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[NUMBER_WIDTH-2:0], 1'b0};
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

// ----- rtl/prime_test_trial_division.sv -----
// Top level of the trial-division primality tester: sequencer and output register.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tdata: number (NUMBER_WIDTH bits, two's complement), zero pad
//  m_axis    out        tdata: is_prime (1 bit), zero pad to 8 bits
//
// One beat is taken while the sequencer is idle. Negative values, 0, 1, 2 and even
// values are settled without a trial and go straight to S_FINISH. Odd values go
// through the odd trial divisors 3, 5, 7, ... while the divisor squared does not
// exceed the number; every trial costs a compare in S_CHECK plus a pass through the
// serial remainder unit, which sets the rate. Reset is synchronous and active low
// and empties the sequencer and the output register. The result waits in the output
// register; a stalled output only holds the sequencer once the next result is
// finished.
module prime_test_trial_division #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // Fields: number [NUMBER_WIDTH-1:0], then zero padding.
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // Fields: is_prime [0], then zero padding.
    output logic [7:0]                           o_m_axis_tdata
);
    import ptd_pkg::*;

    localparam int W = NUMBER_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [W-1:0]  r_num, n_num;
    logic [W-1:0]  r_div, n_div;
    // Square of the current divisor; one extra bit keeps the last step from wrapping.
    logic [W:0]    r_sq, n_sq;
    logic          r_result, n_result;
    logic          r_out_valid, n_out_valid;
    logic          r_out_bit, n_out_bit;

    logic          accept;
    logic          start;
    logic [W-1:0]  in_num;
    t_rem_status   rem_status;

    assign in_num          = i_s_axis_tdata[W-1:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    // A trial starts when the divisor squared still fits under the number.
    assign start           = (r_state == S_CHECK) && (r_sq <= {1'b0, r_num});

    ptd_rem_unit #(
        .NUMBER_WIDTH(W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (r_num),
        .i_divisor  (r_div),
        .o_status   (rem_status)
    );

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_div       = r_div;
        n_sq        = r_sq;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_num = in_num;
                    n_div = W'(3);
                    n_sq  = (W + 1)'(9);
                    priority if (in_num[W-1]) begin
                        // Every negative value is not prime.
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else if (in_num < W'(2)) begin
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else if (in_num == W'(2)) begin
                        n_result = 1'b1;
                        n_state  = S_FINISH;
                    end else if (!in_num[0]) begin
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (start) begin
                    n_state = S_DIV;
                end else begin
                    // No divisor up to the square root divides the number.
                    n_result = 1'b1;
                    n_state  = S_FINISH;
                end
            end
            S_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.rem_zero) begin
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        n_div   = r_div + W'(2);
                        n_sq    = r_sq + (W + 1)'({r_div, 2'b00}) + (W + 1)'(4);
                        n_state = S_CHECK;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= n_num;
        r_div     <= n_div;
        r_sq      <= n_sq;
        r_result  <= n_result;
        r_out_bit <= n_out_bit;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_bit};

endmodule

// ----- bench/prime_verdict_checker.sv -----
`timescale 1ns / 1ps
// Watches both stream channels, predicts each primality verdict and compares it with the output beat.
module prime_verdict_checker #(
    parameter int NUMBER_WIDTH = 32,
    parameter int IN_W         = ((NUMBER_WIDTH + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_axis_tvalid,
    input  logic            i_s_axis_tready,
    // Fields: number [NUMBER_WIDTH-1:0], then zero padding.
    input  logic [IN_W-1:0] i_s_axis_tdata,
    input  logic            i_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // Fields: is_prime [0], then zero padding.
    input  logic [7:0]      i_m_axis_tdata,
    output int              o_fail_count,
    output int              o_pending_count,
    output int              o_verdict_count,
    output int              o_prime_count
);

    typedef struct {
        logic [NUMBER_WIDTH-1:0] number;
        logic                    is_prime;
    } t_verdict;

    t_verdict verdicts_q[$];
    t_verdict oldest;
    int       failures = 0;
    int       verdicts = 0;
    int       primes   = 0;
    int       pending  = 0;

    assign o_fail_count    = failures;
    assign o_verdict_count = verdicts;
    assign o_prime_count   = primes;
    assign o_pending_count = pending;

    // Trial division by 2 and then by odd divisors while the divisor squared stays
    // within the number; a negative number is never prime.
    function automatic logic is_prime_number(input logic [NUMBER_WIDTH-1:0] n);
        logic [NUMBER_WIDTH-1:0] divisor;
        if (n[NUMBER_WIDTH-1])
            return 1'b0;
        if (n < 2)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        for (divisor = 3; divisor <= n / divisor; divisor += 2) begin
            if (n % divisor == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (verdicts_q.size() == 0) begin
                    $error("output beat 0x%02h arrived with no number outstanding",
                           i_m_axis_tdata);
                    failures++;
                end else begin
                    oldest = verdicts_q.pop_front();
                    verdicts++;
                    if (oldest.is_prime)
                        primes++;
                    if (i_m_axis_tdata[0] !== oldest.is_prime) begin
                        $error("is_prime for %0d: expected %0b, actual %0b",
                               $signed(oldest.number), oldest.is_prime, i_m_axis_tdata[0]);
                        failures++;
                    end
                    if (i_m_axis_tdata[7:1] !== 7'd0) begin
                        $error("pad for %0d: expected 0x00, actual 0x%02h",
                               $signed(oldest.number), i_m_axis_tdata[7:1]);
                        failures++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                verdicts_q.push_back('{
                    number:   i_s_axis_tdata[NUMBER_WIDTH-1:0],
                    is_prime: is_prime_number(i_s_axis_tdata[NUMBER_WIDTH-1:0])
                });
            end
            pending <= verdicts_q.size();
        end
    end

endmodule

// ----- bench/prime_test_trial_division_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the trial-division primality tester: stimulus, output pacing and verdict.
module prime_test_trial_division_tb;

    localparam int NUMBER_WIDTH = 32;
    localparam int IN_W         = ((NUMBER_WIDTH + 7) / 8) * 8;
    // Cycles allowed after the last result for any stray beat to show itself.
    localparam int SETTLE_CYCLES = 50;
    // Length of the single long receiver hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES = 400;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [7:0]      m_tdata;

    int fail_count;
    int pending_count;
    int verdict_count;
    int prime_count;

    // Asked for once by the stimulus; the receiver process then refuses beats for a
    // long stretch while the sender keeps offering, so the block backs up.
    logic hold_off_req = 1'b0;

    // While set, the sender offers beats back to back with no gaps.
    bit steady = 1'b0;
    int burst_left = 0;
    int directed_sent = 0;
    int random_sent = 0;

    // Edge cases first: both ends of the signed range, negatives, zero, one, two,
    // small primes and composites, squares of primes, and large values whose answer
    // comes quickly. The largest positive value is itself prime and is by far the
    // slowest item of the run, so it is sent only once.
    logic [NUMBER_WIDTH-1:0] directed_numbers [25] = '{
        32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'd0,         32'd1,
        32'd2,         32'd3,         32'd4,         32'd5,         32'd9,
        32'd25,        32'd49,        32'd121,       32'd63001,     32'd15,
        32'd97,        32'd8191,      32'd65535,     32'd65537,     32'd1000,
        32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF
    };

    always #1 clk = ~clk;

    prime_test_trial_division #(
        .NUMBER_WIDTH   (NUMBER_WIDTH)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    prime_verdict_checker #(
        .NUMBER_WIDTH   (NUMBER_WIDTH)
    ) verdict_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .i_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_m_axis_tdata (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count),
        .o_verdict_count(verdict_count),
        .o_prime_count  (prime_count)
    );

    // Random numbers are shaped so that the run stays short: the cost of a number is
    // set by its smallest factor, so large positive values are either even or built
    // as a multiple of a small odd prime, while genuinely searched values stay small.
    // Negative values carry random low bits so that every bit of the word toggles.
    function automatic logic [NUMBER_WIDTH-1:0] random_number();
        logic [NUMBER_WIDTH-1:0] factor;
        logic [NUMBER_WIDTH-1:0] multiple;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return NUMBER_WIDTH'($urandom_range(0, 4095));
            5:             return NUMBER_WIDTH'($urandom_range(4096, 65535));
            6:             return {1'b1, (NUMBER_WIDTH - 1)'($urandom)};
            7:             return {1'b0, (NUMBER_WIDTH - 2)'($urandom), 1'b0};
            8: begin
                case ($urandom_range(0, 4))
                    0:       factor = 3;
                    1:       factor = 5;
                    2:       factor = 7;
                    3:       factor = 11;
                    default: factor = 13;
                endcase
                multiple = NUMBER_WIDTH'($urandom_range(1, 32'h7FFF_FFFF / factor));
                return multiple * factor;
            end
            default:       return NUMBER_WIDTH'($urandom_range(0, 63));
        endcase
    endfunction

    // Offers one number and returns once the beat is taken and any gap after it is over. Beats go
    // out in bursts of random length; after a burst the valid is dropped for a random
    // gap. A long burst now and then gives stretches with no idling at all.
    task automatic offer_number(input logic [NUMBER_WIDTH-1:0] value);
        int gap;
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        if (steady || burst_left > 0) begin
            if (burst_left > 0)
                burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Stops offering and waits until every predicted verdict has come out. The first
    // edge lets the checker count a beat that was taken at the current edge.
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Receiver: for each window a new pattern is picked, from always ready through
    // random stalls to a full window of back-pressure. The one long hold-off is
    // counted here, in this process, once the stimulus asks for it.
    initial begin
        int window_left;
        int mode;
        int held_cycles;
        bit held;
        window_left = 0;
        mode        = 0;
        held        = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req && !held) begin
                held        = 1'b1;
                m_tready   <= 1'b0;
                held_cycles = 0;
                while (held_cycles < HOLD_OFF_CYCLES) begin
                    @(posedge clk);
                    held_cycles++;
                end
            end else begin
                if (window_left == 0) begin
                    mode        = $urandom_range(0, 4);
                    window_left = 32;
                end
                window_left--;
                case (mode)
                    0, 1:    m_tready <= 1'b1;
                    2:       m_tready <= $urandom_range(0, 1);
                    3:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= 1'b0;
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_numbers[i]) begin
            offer_number(directed_numbers[i]);
            directed_sent++;
        end

        // The sender waits here until every directed verdict is back.
        drain_verdicts();

        // Long receiver hold-off while the sender keeps offering quick numbers back
        // to back: the output register and the sequencer fill and the input stalls.
        hold_off_req <= 1'b1;
        steady        = 1'b1;
        for (int i = 0; i < 8; i++) begin
            offer_number(NUMBER_WIDTH'($urandom_range(0, 40)));
            random_sent++;
        end
        steady = 1'b0;

        for (int i = 0; i < 70; i++) begin
            offer_number(random_number());
            random_sent++;
        end

        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d directed and %0d random numbers, %0d verdicts checked,",
                 directed_sent, random_sent, verdict_count);
        $display("%0d of them prime, with gaps, stalls and one long output hold-off.",
                 prime_count);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guard against a hung block: far beyond the slowest correct run, which is set
    // by the single largest prime.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
